// ===== design/fct_pkg.sv =====
`default_nettype none
package fct_pkg;

	// table geometry
	localparam int unsigned ENTRIES    = 4096;
	localparam int unsigned ADDR_W     = $clog2(ENTRIES);
	localparam int unsigned INDEX_SPAN = 4096;
	localparam int unsigned SEARCH_END = (ENTRIES < INDEX_SPAN) ? ENTRIES : INDEX_SPAN;

	// field widths
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned INDEX_W = 12;
	localparam int unsigned DATA_W  = 16;
	localparam int unsigned CNT_W   = 10;
	localparam int unsigned PTR_W   = INDEX_W + 1;
	localparam int unsigned LIM_W   = 17;
	localparam int unsigned CFG_W   = 2;

	// register reset values
	localparam logic [DATA_W-1:0]  EMPTY_RESET = 16'd0;
	localparam logic [INDEX_W-1:0] START_RESET = 12'd10;
	localparam logic [CNT_W-1:0]   SAVE_RESET  = 10'd16;

	typedef enum logic [CMD_W-1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_FIND  = 2'd2
	} cmd_t;

	typedef enum logic [CFG_W-1:0] {
		CFG_EMPTY_CODE    = 2'd0,
		CFG_SEARCH_START  = 2'd1,
		CFG_SAVE_INTERVAL = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_READ   = 3'b010,
		ST_SEARCH = 3'b100
	} state_t;

	// true when a 12-bit index lies inside the table
	function automatic logic in_table(input logic [INDEX_W-1:0] idx);
		logic [LIM_W-1:0] ext;
		ext = {{(LIM_W-INDEX_W){1'b0}}, idx};
		return ext < LIM_W'(ENTRIES);
	endfunction

	// table address of an index already known to be inside the table
	function automatic logic [ADDR_W-1:0] to_addr(input logic [INDEX_W-1:0] idx);
		logic [LIM_W-1:0] ext;
		ext = {{(LIM_W-INDEX_W){1'b0}}, idx};
		return ext[ADDR_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== design/fat_cluster_table.sv =====
`default_nettype none
// Cluster table of fct_pkg::ENTRIES 16-bit entries in one synchronous RAM with a single
// read and a single write port. A write loads its result straight from idle; a read
// first passes through the registered RAM read. A free search examines the entries
// from search_start up to the first free one or the end of the table: the read port
// delivers one entry per cycle while the output is not stalled and the compare uses
// the registered read data. Only one item is in work at a time; a finished result
// sits in the output register while the next item is taken, and a stalled output
// freezes the block. Entries are not cleared at reset; unwritten ones are undefined.
module fat_cluster_table (
	input  wire logic                         clk,
	input  wire logic                         arst_n,

	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [fct_pkg::CFG_W-1:0]    cfg_index,
	input  wire logic [fct_pkg::DATA_W-1:0]   cfg_data,

	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [fct_pkg::CMD_W-1:0]    cmd,
	input  wire logic [fct_pkg::INDEX_W-1:0]  index,
	input  wire logic [fct_pkg::DATA_W-1:0]   data,

	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [fct_pkg::DATA_W-1:0]        read_data,
	output logic                              found,
	output logic [fct_pkg::INDEX_W-1:0]       free_index,
	output logic                              flush
);

	logic [fct_pkg::DATA_W-1:0]  mem [fct_pkg::ENTRIES];
	logic [fct_pkg::DATA_W-1:0]  rdata_q;

	logic [fct_pkg::DATA_W-1:0]  empty_code_q;
	logic [fct_pkg::INDEX_W-1:0] search_start_q;
	logic [fct_pkg::CNT_W-1:0]   save_interval_q;
	logic [fct_pkg::CNT_W-1:0]   save_cnt_q;

	fct_pkg::state_t             state_q, state_d;
	logic [fct_pkg::PTR_W-1:0]   ptr_q, ptr_d;
	logic                        chk_s1, chk_d;
	logic [fct_pkg::INDEX_W-1:0] chk_idx_s1, chk_idx_d;

	logic                        out_valid_q;
	logic [fct_pkg::DATA_W-1:0]  read_data_q;
	logic                        found_q;
	logic [fct_pkg::INDEX_W-1:0] free_index_q;
	logic                        flush_q;

	logic                        out_free;
	logic                        in_acc;
	logic                        mem_re, mem_we;
	logic [fct_pkg::ADDR_W-1:0]  mem_raddr, mem_waddr;
	logic                        cnt_upd;
	logic [fct_pkg::CNT_W-1:0]   cnt_d;
	logic                        ld_out;
	logic [fct_pkg::DATA_W-1:0]  res_data;
	logic                        res_found;
	logic [fct_pkg::INDEX_W-1:0] res_index;
	logic                        res_flush;

	assign cfg_ready  = 1'b1;
	assign out_free   = !out_valid_q || !out_stall;
	assign in_stall   = (state_q != fct_pkg::ST_IDLE) || !out_free;
	assign in_acc     = in_valid && !in_stall;

	assign out_valid  = out_valid_q;
	assign read_data  = read_data_q;
	assign found      = found_q;
	assign free_index = free_index_q;
	assign flush      = flush_q;

	always_comb begin
		state_d   = state_q;
		ptr_d     = ptr_q;
		chk_d     = chk_s1;
		chk_idx_d = chk_idx_s1;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_raddr = '0;
		mem_waddr = fct_pkg::to_addr(index);
		cnt_upd   = 1'b0;
		cnt_d     = save_cnt_q;
		ld_out    = 1'b0;
		res_data  = '0;
		res_found = 1'b0;
		res_index = '0;
		res_flush = 1'b0;
		unique case (state_q)
			fct_pkg::ST_IDLE: begin
				if (in_acc) begin
					unique case (cmd)
						fct_pkg::CMD_READ: begin
							if (fct_pkg::in_table(index)) begin
								mem_re    = 1'b1;
								mem_raddr = fct_pkg::to_addr(index);
								state_d   = fct_pkg::ST_READ;
							end else begin
								ld_out = 1'b1;
							end
						end
						fct_pkg::CMD_WRITE: begin
							ld_out = 1'b1;
							if (fct_pkg::in_table(index)) begin
								mem_we  = 1'b1;
								cnt_upd = 1'b1;
								if (save_cnt_q == '0) begin
									res_flush = 1'b1;
									cnt_d     = save_interval_q;
								end else begin
									cnt_d = save_cnt_q - 1'b1;
								end
							end
						end
						fct_pkg::CMD_FIND: begin
							ptr_d   = {1'b0, search_start_q};
							chk_d   = 1'b0;
							state_d = fct_pkg::ST_SEARCH;
						end
						default: begin
							ld_out = 1'b1;
						end
					endcase
				end
			end
			fct_pkg::ST_READ: begin
				if (out_free) begin
					ld_out   = 1'b1;
					res_data = rdata_q;
					state_d  = fct_pkg::ST_IDLE;
				end
			end
			fct_pkg::ST_SEARCH: begin
				// hold the whole scan while the output is blocked
				if (out_free) begin
					if (chk_s1 && (rdata_q == empty_code_q)) begin
						ld_out    = 1'b1;
						res_found = 1'b1;
						res_index = chk_idx_s1;
						chk_d     = 1'b0;
						state_d   = fct_pkg::ST_IDLE;
					end else if (ptr_q < fct_pkg::PTR_W'(fct_pkg::SEARCH_END)) begin
						mem_re    = 1'b1;
						mem_raddr = fct_pkg::to_addr(ptr_q[fct_pkg::INDEX_W-1:0]);
						chk_d     = 1'b1;
						chk_idx_d = ptr_q[fct_pkg::INDEX_W-1:0];
						ptr_d     = ptr_q + 1'b1;
					end else begin
						ld_out  = 1'b1;
						chk_d   = 1'b0;
						state_d = fct_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = fct_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= data;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_code_q    <= fct_pkg::EMPTY_RESET;
			search_start_q  <= fct_pkg::START_RESET;
			save_interval_q <= fct_pkg::SAVE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fct_pkg::CFG_EMPTY_CODE:    empty_code_q    <= cfg_data;
				fct_pkg::CFG_SEARCH_START:  search_start_q  <= cfg_data[fct_pkg::INDEX_W-1:0];
				fct_pkg::CFG_SAVE_INTERVAL: save_interval_q <= cfg_data[fct_pkg::CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fct_pkg::ST_IDLE;
			chk_s1      <= 1'b0;
			save_cnt_q  <= fct_pkg::SAVE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			chk_s1  <= chk_d;
			if (cnt_upd) begin
				save_cnt_q <= cnt_d;
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ptr_q      <= ptr_d;
		chk_idx_s1 <= chk_idx_d;
		if (ld_out) begin
			read_data_q  <= res_data;
			found_q      <= res_found;
			free_index_q <= res_index;
			flush_q      <= res_flush;
		end
	end

endmodule
`default_nettype wire
